// ----- design/fdg_pkg.sv -----
package fdg_pkg;

  localparam int TAPS_PER_PHASE = 32;
  localparam int MAX_DECIM      = 6;
  localparam int HIST_DEPTH     = TAPS_PER_PHASE * MAX_DECIM;

  // Address width for the history and coefficient stores, and a count
  // width that can also hold the depth itself.
  localparam int AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(HIST_DEPTH + 1);

  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int DEC_W  = 3;
  localparam int PH_W   = 3;
  localparam int HIST_W = 22;
  localparam int COEF_W = 16;
  localparam int IDX_W  = 8;
  localparam int PROD_W = HIST_W + COEF_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int MAG_W  = 30;
  localparam int SCL_W  = MAG_W + 15;

  localparam logic [GAIN_W-1:0] GAIN_MIN   = 16'd102;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd51200;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1024;
  localparam logic [DEC_W-1:0]  DEC_RESET  = 3'd6;
  localparam longint            CLAMP_Q30  = 64'sd1072668082;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_DECIM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_SAMPLE,
    ST_MAC,
    ST_DRAIN,
    ST_CLAMP,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic coef_wr;
    logic sample_wr;
    logic mac_issue;
    logic fin_clamp;
    logic fin_scale;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fire;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/fdg_ctrl.sv -----
module fdg_ctrl import fdg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_action_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_action_i == ACT_COEF) ? ST_COEF : ST_SAMPLE;
        end
      end
      ST_COEF: begin
        cmd_o.coef_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SAMPLE: begin
        cmd_o.sample_wr = 1'b1;
        state_d = status_i.fire ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (status_i.last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.fin_clamp = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.fin_scale = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/fdg_datapath.sv -----
module fdg_datapath import fdg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic [DEC_W-1:0]         decim_i,
  input  logic                     decim_wr_i,
  input  logic signed [SMP_W-1:0]  in_sample_i,
  input  logic [IDX_W-1:0]         in_coef_index_i,
  input  logic signed [COEF_W-1:0] in_coef_value_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [SMP_W-1:0]  out_sample_o,
  output logic                     out_clipped_o
);

  localparam logic signed [ACC_W-1:0] CLAMP_POS = ACC_W'(CLAMP_Q30);
  localparam logic signed [ACC_W-1:0] CLAMP_NEG = -ACC_W'(CLAMP_Q30);

  // Request payload.
  logic signed [SMP_W-1:0]  smp_q;
  logic [IDX_W-1:0]         cidx_q;
  logic signed [COEF_W-1:0] cval_q;

  // Stores.
  logic signed [HIST_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [COEF_W-1:0] coef_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]    hist_vld_q;

  logic [AW-1:0]   wp_q;
  logic [PH_W-1:0] phase_q;
  logic [AW-1:0]   idx_q;
  logic [AW-1:0]   j_q;

  logic signed [HIST_W-1:0] hist_rd_q;
  logic signed [COEF_W-1:0] coef_rd_q;
  logic                     hist_rd_vld_q;
  logic                     s1_v_q, s2_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic             neg_q, clip_q;
  logic [MAG_W-1:0] mag_q;
  logic [SCL_W-1:0] scl_q;
  logic             fneg_q, fclip_q;

  logic                    out_valid_q;
  logic signed [SMP_W-1:0] out_sample_q;
  logic                    out_clipped_q;

  // Effective settings.
  logic [DEC_W-1:0]  eff_d;
  logic [CNT_W-1:0]  total;
  logic [GAIN_W-1:0] g_eff;

  always_comb begin
    eff_d = decim_i;
    if (eff_d == '0) begin
      eff_d = DEC_W'(1);
    end
    if (int'(eff_d) > MAX_DECIM) begin
      eff_d = DEC_W'(MAX_DECIM);
    end
    g_eff = gain_i;
    if (g_eff < GAIN_MIN) begin
      g_eff = GAIN_MIN;
    end
    if (g_eff > GAIN_MAX) begin
      g_eff = GAIN_MAX;
    end
  end

  assign total = CNT_W'(TAPS_PER_PHASE) * CNT_W'(eff_d);

  // Gain and saturation to the history format.
  logic signed [SMP_W+GAIN_W:0] prod_g;
  logic signed [SMP_W+GAIN_W:0] shifted;
  logic signed [HIST_W-1:0]     scaled;
  logic                         in_range;

  assign prod_g   = smp_q * $signed({1'b0, g_eff});
  assign shifted  = prod_g >>> 10;
  assign in_range = (&shifted[SMP_W+GAIN_W:HIST_W-1]) | ~(|shifted[SMP_W+GAIN_W:HIST_W-1]);

  always_comb begin
    if (in_range) begin
      scaled = shifted[HIST_W-1:0];
    end else if (shifted[SMP_W+GAIN_W]) begin
      scaled = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // Write pointer and phase.
  logic [AW-1:0]    wp_eff, wp_next, rd_idx;
  logic [CNT_W-1:0] wp_inc;
  logic [PH_W-1:0]  phase_inc;

  assign wp_eff    = (CNT_W'(wp_q) >= total) ? '0 : wp_q;
  assign wp_inc    = CNT_W'(wp_eff) + CNT_W'(1);
  assign wp_next   = (wp_inc == total) ? '0 : AW'(wp_inc);
  assign phase_inc = phase_q + PH_W'(1);
  assign rd_idx    = (idx_q == '0) ? AW'(total - CNT_W'(1)) : idx_q - AW'(1);

  assign status_o.fire      = (phase_inc >= PH_W'(eff_d));
  assign status_o.last_tap  = (CNT_W'(j_q) == total - CNT_W'(1));
  assign status_o.pipe_busy = s1_v_q | s2_v_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      smp_q  <= in_sample_i;
      cidx_q <= in_coef_index_i;
      cval_q <= in_coef_value_i;
    end
  end

  // History and coefficient memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_wr) begin
      hist_mem[wp_eff] <= scaled;
    end
    if (cmd_i.coef_wr && (int'(cidx_q) < HIST_DEPTH)) begin
      coef_mem[AW'(cidx_q)] <= cval_q;
    end
    if (cmd_i.mac_issue) begin
      hist_rd_q <= hist_mem[rd_idx];
      coef_rd_q <= coef_mem[j_q];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q    <= '0;
      hist_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.sample_wr) begin
        hist_vld_q[wp_eff] <= 1'b1;
      end
      if (cmd_i.mac_issue) begin
        hist_rd_vld_q <= hist_vld_q[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      phase_q <= '0;
      idx_q   <= '0;
      j_q     <= '0;
    end else if (decim_wr_i) begin
      wp_q    <= '0;
      phase_q <= '0;
    end else if (cmd_i.sample_wr) begin
      wp_q <= wp_next;
      if (status_o.fire) begin
        phase_q <= '0;
        idx_q   <= wp_next;
        j_q     <= '0;
      end else begin
        phase_q <= phase_inc;
      end
    end else if (cmd_i.mac_issue) begin
      idx_q <= rd_idx;
      j_q   <= j_q + AW'(1);
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  logic signed [HIST_W-1:0] hist_eff;
  assign hist_eff = hist_rd_vld_q ? hist_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.mac_issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      prod_q <= hist_eff * coef_rd_q;
    end
    if (cmd_i.sample_wr) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Clamp, then scale by 32767 as (m << 15) - m, then truncate.
  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W-1:0] acc_abs;
  logic                    clip_c;

  always_comb begin
    acc_c  = acc_q;
    clip_c = 1'b0;
    if (acc_q > CLAMP_POS) begin
      acc_c  = CLAMP_POS;
      clip_c = 1'b1;
    end
    if (acc_q < CLAMP_NEG) begin
      acc_c  = CLAMP_NEG;
      clip_c = 1'b1;
    end
    acc_abs = acc_c[ACC_W-1] ? -acc_c : acc_c;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_clamp) begin
      neg_q  <= acc_c[ACC_W-1];
      clip_q <= clip_c;
      mag_q  <= acc_abs[MAG_W-1:0];
    end
    if (cmd_i.fin_scale) begin
      scl_q   <= {mag_q, 15'd0} - SCL_W'(mag_q);
      fneg_q  <= neg_q;
      fclip_q <= clip_q;
    end
  end

  logic signed [SMP_W-1:0] q_mag;
  assign q_mag = $signed({1'b0, scl_q[SCL_W-1:MAG_W]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q  <= fneg_q ? -q_mag : q_mag;
      out_clipped_q <= fclip_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_clipped_o = out_clipped_q;

endmodule

// ----- design/fir_decimator_with_gain_core.sv -----
// Decimating FIR filter with input gain for a mono audio stream.
// Requests arrive on the in_* valid/ready channel. A request with action
// zero carries an audio sample; it is scaled by the gain register and
// stored in the sample history. A request with action one loads one
// coefficient of the tap store. Every decim_factor-th sample (0 is taken
// as 1, values above 6 as 6) launches a filter pass over 32 * decim_factor
// taps on one shared multiply-accumulate unit, one tap per cycle, and the
// result leaves on the out_* channel. The block takes a request only when
// idle, so none is accepted while a coefficient or sample is written or a
// filter pass runs. A pass steps through the tap loop, the drain of the MAC
// pipeline, clamp, scale and the output load; its rate is set by the
// tap loop through the single MAC and the history read port.
// The result sits in an output register: new requests are accepted while
// it waits, and only the next result stalls if the receiver holds ready low.
// Reset clears the sample history (per-entry valid flags, no sweep), the
// write pointer and phase, and restores gain 1.0 and decim_factor 6. The
// coefficient store is not cleared and must be loaded before use.
// Registers sit on an APB port at 0x0 (gain) and 0x4 (decim_factor);
// writing decim_factor restarts the write pointer and phase.
module fir_decimator_with_gain_core import fdg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_action_i,
  input  logic signed [SMP_W-1:0]  in_sample_i,
  input  logic [IDX_W-1:0]         in_coef_index_i,
  input  logic signed [COEF_W-1:0] in_coef_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SMP_W-1:0]  out_sample_o,
  output logic                     out_clipped_o
);

  logic [GAIN_W-1:0] gain_q;
  logic [DEC_W-1:0]  decim_q;
  logic              cfg_wr;
  logic              decim_wr;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign decim_wr = cfg_wr && (paddr[2] == REG_DECIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      decim_q <= DEC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GAIN) begin
        gain_q <= pwdata[GAIN_W-1:0];
      end else begin
        decim_q <= pwdata[DEC_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GAIN) ? 32'(gain_q) : 32'(decim_q);

  fdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fdg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .gain_i          (gain_q),
    .decim_i         (decim_q),
    .decim_wr_i      (decim_wr),
    .in_sample_i     (in_sample_i),
    .in_coef_index_i (in_coef_index_i),
    .in_coef_value_i (in_coef_value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_sample_o    (out_sample_o),
    .out_clipped_o   (out_clipped_o)
  );

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while the previous one is still pending");

  // The accumulator is complete before the clamp stage samples it.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_clamp |-> !status.pipe_busy)
    else $error("clamp taken while the MAC pipeline still holds taps");

  // A tap read always enters the MAC pipeline on the next cycle.
  a_issue_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mac_issue |=> status.pipe_busy)
    else $error("tap read did not reach the MAC pipeline");

endmodule
